/* rtl/core/bat_pkg.sv */
// Shared types, widths and constant tables of the bulge arc tessellator.
package bat_pkg;

   // field widths
   localparam int COORD_W = 24;
   localparam int BULGE_W = 16;
   localparam int INDEX_W = 4;
   localparam int REQ_W   = 112;
   localparam int RSP_W   = 56;

   // internal widths
   localparam int CORD_W  = 40;   // CORDIC x and y
   localparam int ANG_W   = 34;   // CORDIC angle accumulator
   localparam int DIV_W   = 60;   // divider dividend and quotient
   localparam int DEN_W   = 16;   // divider divisor
   localparam int ACC_W   = 64;   // centre, vector and point accumulators
   localparam int TRIG_W  = 33;   // cos and sin, Q2.30 with headroom

   localparam int ITERS      = 30;
   localparam int NUM_THRESH = 7;

   localparam logic [CORD_W-1:0] GAIN_INV = 40'h00_26DD_3B6A;

   // atan(2^-k) in 2^-32 turn
   localparam logic [31:0] ATAN_TAB [ITERS] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
   };

   // bulge magnitudes at which one more segment is added
   localparam logic [15:0] SEG_THRESH [NUM_THRESH] = '{
      16'd3143, 16'd4096, 16'd5339, 16'd7095, 16'd9889, 16'd15287, 16'd31113
   };

   // datapath commands
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ATAN_GO,
      OP_ATAN_END,
      OP_MULX,
      OP_MULY,
      OP_DIV_GO,
      OP_CX_END,
      OP_CY_END,
      OP_VEC,
      OP_PHI_GO,
      OP_ROT_GO,
      OP_ROT_END,
      OP_MAC_GO,
      OP_EMIT
   } op_type;

   // datapath status
   typedef struct packed {
      logic skip;
      logic cordic_busy;
      logic div_busy;
      logic mac_busy;
      logic last;
      logic out_busy;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_ATAN,
      ST_MULX,
      ST_DIVX,
      ST_DIVX_W,
      ST_MULY,
      ST_DIVY,
      ST_DIVY_W,
      ST_VEC,
      ST_PHI,
      ST_PHI_W,
      ST_ROT_W,
      ST_MAC,
      ST_MAC_W,
      ST_EMIT
   } state_type;

endpackage

/* rtl/core/bat_cordic.sv */
// Shared iterative CORDIC unit, vectoring or rotation, one step per cycle.
module bat_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               vec_mode,
   input  logic signed [bat_pkg::CORD_W-1:0]  x_init,
   input  logic signed [bat_pkg::CORD_W-1:0]  y_init,
   input  logic signed [bat_pkg::ANG_W-1:0]   z_init,
   output logic                               busy,
   output logic signed [bat_pkg::CORD_W-1:0]  x_out,
   output logic signed [bat_pkg::CORD_W-1:0]  y_out,
   output logic signed [bat_pkg::ANG_W-1:0]   z_out
);
   import bat_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     vec_ff, vec_in;
   logic [4:0]               iter_ff, iter_in;
   logic signed [CORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANG_W-1:0]  z_ff, z_in;
   logic signed [CORD_W-1:0] sx, sy;
   logic signed [ANG_W-1:0]  step_ang;
   logic                     dir;

   // one micro-rotation; dir picks the add direction of x and the angle
   always_comb begin
      sx       = y_ff >>> iter_ff;
      sy       = x_ff >>> iter_ff;
      step_ang = $signed({2'b00, ATAN_TAB[iter_ff]});
      dir      = vec_ff ? !y_ff[CORD_W-1] : z_ff[ANG_W-1];
      busy_in  = busy_ff;
      vec_in   = vec_ff;
      iter_in  = iter_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      if (start) begin
         busy_in = 1'b1;
         vec_in  = vec_mode;
         iter_in = '0;
         x_in    = x_init;
         y_in    = y_init;
         z_in    = z_init;
      end else if (busy_ff) begin
         if (dir) begin
            x_in = x_ff + sx;
            y_in = y_ff - sy;
            z_in = z_ff + step_ang;
         end else begin
            x_in = x_ff - sx;
            y_in = y_ff + sy;
            z_in = z_ff - step_ang;
         end
         iter_in = iter_ff + 5'd1;
         if (iter_ff == 5'(ITERS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      vec_ff  <= vec_in;
      iter_ff <= iter_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   assign busy  = busy_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

/* rtl/core/bat_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module bat_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [bat_pkg::DIV_W-1:0]   num,
   input  logic [bat_pkg::DEN_W-1:0]   den,
   output logic                        busy,
   output logic [bat_pkg::DIV_W-1:0]   quo
);
   import bat_pkg::*;

   logic             busy_ff, busy_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // shift the next dividend bit into the remainder and try a subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

/* rtl/core/bat_datapath.sv */
// Datapath: arc registers, centre and point arithmetic, result register.
module bat_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  bat_pkg::op_type              op,
   output bat_pkg::status_type          status,
   input  logic [bat_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [bat_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                         rsp_tlast
);
   import bat_pkg::*;

   // request fields
   logic signed [COORD_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;
   logic signed [BULGE_W-1:0] b_ff;
   logic signed [31:0]        t_ff;
   logic signed [31:0]        bb;

   // arc values
   logic [15:0]               ab;
   logic [INDEX_W-1:0]        n;
   logic [INDEX_W-1:0]        i_ff;
   logic [31:0]               ang_ff;
   logic [53:0]               prod_ff;
   logic                      neg_ff;
   logic signed [ACC_W-1:0]   cx_ff, cy_ff, vx_ff, vy_ff;
   logic signed [ACC_W-1:0]   px_ff, py_ff;
   logic signed [TRIG_W-1:0]  c_ff, s_ff;
   logic [1:0]                quad_ff;

   // differences and magnitudes
   logic signed [COORD_W:0]   dx, dy, dsum_x, dsum_y, adx, ady;
   logic signed [31:0]        at;
   logic                      t_neg;

   // shared units
   logic                      cor_start, cor_vec, cor_busy;
   logic signed [CORD_W-1:0]  cor_x0, cor_y0, cor_x, cor_y;
   logic signed [ANG_W-1:0]   cor_z0, cor_z;
   logic                      div_start, div_busy;
   logic [DIV_W-1:0]          div_num, div_quo;
   logic [DEN_W-1:0]          div_den;

   // rotation angle and cordic results
   logic [31:0]               f, u;
   logic [29:0]               zc;
   logic signed [TRIG_W-1:0]  xr, yr;
   logic signed [ACC_W-1:0]   off;

   // multiply-accumulate sequencer
   logic                      mac_busy_ff;
   logic [1:0]                term_ff, phase_ff;
   logic [63:0]               p_hi_ff, p_lo_ff;
   logic signed [ACC_W-1:0]   mac_a;
   logic signed [TRIG_W-1:0]  mac_c;
   logic [ACC_W-1:0]          ua;
   logic [31:0]               uc;
   logic [64:0]               r;
   logic                      r_neg;

   // result register
   logic                      rsp_valid_ff;
   logic [COORD_W-1:0]        ox_ff, oy_ff;
   logic [INDEX_W-1:0]        oi_ff;
   logic                      ol_ff;

   // Q.24 to Q15.8, rounded and saturated
   function automatic logic [COORD_W-1:0] to_out(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] w;
      w = (v + ACC_W'(32768)) >>> 16;
      if (w > ACC_W'(signed'(24'sh7FFFFF))) begin
         to_out = 24'h7FFFFF;
      end else if (w < -ACC_W'(64'sd8388608)) begin
         to_out = 24'h800000;
      end else begin
         to_out = w[COORD_W-1:0];
      end
   endfunction

   // segment count and bulge magnitude
   always_comb begin
      ab = b_ff[BULGE_W-1] ? 16'(-b_ff) : 16'(b_ff);
      n  = INDEX_W'(4);
      for (int k = 0; k < NUM_THRESH; k++) begin
         if (ab >= SEG_THRESH[k]) begin
            n = n + INDEX_W'(1);
         end
      end
   end

   // endpoint differences
   always_comb begin
      dx     = (COORD_W+1)'(x2_ff) - (COORD_W+1)'(x1_ff);
      dy     = (COORD_W+1)'(y2_ff) - (COORD_W+1)'(y1_ff);
      dsum_x = (COORD_W+1)'(x1_ff) + (COORD_W+1)'(x2_ff);
      dsum_y = (COORD_W+1)'(y1_ff) + (COORD_W+1)'(y2_ff);
      adx    = dx[COORD_W] ? -dx : dx;
      ady    = dy[COORD_W] ? -dy : dy;
      t_neg  = t_ff[31];
      at     = t_neg ? -t_ff : t_ff;
      bb     = 32'(signed'(req_tdata[111:96])) * 32'(signed'(req_tdata[111:96]));
   end

   // unit operand selection
   always_comb begin
      f          = div_quo[31:0];
      u          = b_ff[BULGE_W-1] ? 32'(0 - f) : f;
      cor_start  = (op == OP_ATAN_GO) || (op == OP_ROT_GO);
      cor_vec    = (op == OP_ATAN_GO);
      cor_x0     = (op == OP_ATAN_GO) ? CORD_W'(41'sd1 <<< 30) : signed'(GAIN_INV);
      cor_y0     = (op == OP_ATAN_GO) ? $signed({6'b0, ab, 18'b0}) : '0;
      cor_z0     = (op == OP_ATAN_GO) ? '0 : $signed({4'b0, u[29:0]});
      div_start  = (op == OP_DIV_GO) || (op == OP_PHI_GO);
      if (op == OP_PHI_GO) begin
         div_num = DIV_W'(ang_ff) * DIV_W'(i_ff);
         div_den = DEN_W'(n);
      end else begin
         div_num = DIV_W'({prod_ff, 2'b00}) + DIV_W'(ab >> 1);
         div_den = ab;
      end
   end

   // clamped atan and signed centre offset
   always_comb begin
      if (cor_z[ANG_W-1]) begin
         zc = '0;
      end else if (cor_z > ANG_W'(34'sd1073741823)) begin
         zc = 30'h3FFFFFFF;
      end else begin
         zc = cor_z[29:0];
      end
      off = neg_ff ? -$signed({4'b0, div_quo}) : $signed({4'b0, div_quo});
      xr  = cor_x[TRIG_W-1:0];
      yr  = cor_y[TRIG_W-1:0];
   end

   // operands of the current product term
   always_comb begin
      unique case (term_ff)
         2'd0: begin mac_a = vx_ff; mac_c = c_ff; end
         2'd1: begin mac_a = vy_ff; mac_c = s_ff; end
         2'd2: begin mac_a = vx_ff; mac_c = s_ff; end
         default: begin mac_a = vy_ff; mac_c = c_ff; end
      endcase
      ua    = mac_a[ACC_W-1] ? ACC_W'(-mac_a) : ACC_W'(mac_a);
      uc    = mac_c[TRIG_W-1] ? 32'(-mac_c) : 32'(mac_c);
      r     = {p_hi_ff[62:0], 2'b00} + 65'((65'(p_lo_ff) + 65'(1 << 29)) >> 30);
      r_neg = mac_a[ACC_W-1] ^ mac_c[TRIG_W-1] ^ (term_ff == 2'd1);
   end

   // arc registers
   always_ff @(posedge clock) begin
      unique case (op)
         OP_LOAD: begin
            x1_ff <= req_tdata[23:0];
            y1_ff <= req_tdata[47:24];
            x2_ff <= req_tdata[71:48];
            y2_ff <= req_tdata[95:72];
            b_ff  <= req_tdata[111:96];
            t_ff  <= 32'sd16777216 - bb;
         end
         OP_ATAN_END: ang_ff <= {zc, 2'b00};
         OP_MULX: begin
            prod_ff <= 54'(ady[23:0]) * 54'(at[29:0]);
            neg_ff  <= (dy[COORD_W] == t_neg) ^ b_ff[BULGE_W-1];
         end
         OP_MULY: begin
            prod_ff <= 54'(adx[23:0]) * 54'(at[29:0]);
            neg_ff  <= (dx[COORD_W] ^ t_neg) ^ b_ff[BULGE_W-1];
         end
         OP_CX_END: cx_ff <= (ACC_W'(dsum_x) <<< 15) + off;
         OP_CY_END: cy_ff <= (ACC_W'(dsum_y) <<< 15) + off;
         OP_VEC: begin
            vx_ff <= (ACC_W'(x1_ff) <<< 16) - cx_ff;
            vy_ff <= (ACC_W'(y1_ff) <<< 16) - cy_ff;
            i_ff  <= INDEX_W'(1);
         end
         OP_ROT_GO: quad_ff <= u[31:30];
         OP_ROT_END: begin
            unique case (quad_ff)
               2'd0: begin c_ff <= xr;  s_ff <= yr;  end
               2'd1: begin c_ff <= -yr; s_ff <= xr;  end
               2'd2: begin c_ff <= -xr; s_ff <= -yr; end
               default: begin c_ff <= yr;  s_ff <= -xr; end
            endcase
         end
         OP_EMIT: i_ff <= i_ff + INDEX_W'(1);
         default: begin
         end
      endcase
   end

   // product terms: high partial, low partial, then round and accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         mac_busy_ff <= 1'b0;
      end else if (op == OP_MAC_GO) begin
         mac_busy_ff <= 1'b1;
      end else if (mac_busy_ff && (phase_ff == 2'd2) && (term_ff == 2'd3)) begin
         mac_busy_ff <= 1'b0;
      end
      if (op == OP_ROT_END) begin
         px_ff <= cx_ff;
         py_ff <= cy_ff;
      end
      if (op == OP_MAC_GO) begin
         term_ff  <= '0;
         phase_ff <= '0;
      end else if (mac_busy_ff) begin
         case (phase_ff)
            2'd0: begin
               p_hi_ff  <= ua[63:32] * uc;
               phase_ff <= 2'd1;
            end
            2'd1: begin
               p_lo_ff  <= ua[31:0] * uc;
               phase_ff <= 2'd2;
            end
            default: begin
               if (term_ff[1]) begin
                  py_ff <= r_neg ? py_ff - ACC_W'(r) : py_ff + ACC_W'(r);
               end else begin
                  px_ff <= r_neg ? px_ff - ACC_W'(r) : px_ff + ACC_W'(r);
               end
               term_ff  <= term_ff + 2'd1;
               phase_ff <= 2'd0;
            end
         endcase
      end
   end

   // result register: load on emit, drop when the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (op == OP_EMIT) begin
         ox_ff <= to_out(px_ff);
         oy_ff <= to_out(py_ff);
         oi_ff <= i_ff;
         ol_ff <= (i_ff == n - INDEX_W'(1));
      end
   end

   bat_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .start    (cor_start),
      .vec_mode (cor_vec),
      .x_init   (cor_x0),
      .y_init   (cor_y0),
      .z_init   (cor_z0),
      .busy     (cor_busy),
      .x_out    (cor_x),
      .y_out    (cor_y),
      .z_out    (cor_z)
   );

   bat_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .quo   (div_quo)
   );

   // status to the controller
   always_comb begin
      status.skip        = (b_ff == '0) || ((dx == '0) && (dy == '0));
      status.cordic_busy = cor_busy;
      status.div_busy    = div_busy;
      status.mac_busy    = mac_busy_ff;
      status.last        = (i_ff == n - INDEX_W'(1));
      status.out_busy    = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, oi_ff, oy_ff, ox_ff};
   assign rsp_tlast  = ol_ff;

endmodule

/* rtl/core/bat_ctrl.sv */
// Controller: sequences one arc through the shared datapath units.
module bat_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bat_pkg::status_type  status,
   output bat_pkg::op_type      op
);
   import bat_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and command
   always_comb begin
      state_in   = state_ff;
      op         = OP_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op       = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.skip) begin
               state_in = ST_IDLE;
            end else begin
               op       = OP_ATAN_GO;
               state_in = ST_ATAN;
            end
         end
         ST_ATAN: begin
            if (!status.cordic_busy) begin
               op       = OP_ATAN_END;
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            op       = OP_MULX;
            state_in = ST_DIVX;
         end
         ST_DIVX: begin
            op       = OP_DIV_GO;
            state_in = ST_DIVX_W;
         end
         ST_DIVX_W: begin
            if (!status.div_busy) begin
               op       = OP_CX_END;
               state_in = ST_MULY;
            end
         end
         ST_MULY: begin
            op       = OP_MULY;
            state_in = ST_DIVY;
         end
         ST_DIVY: begin
            op       = OP_DIV_GO;
            state_in = ST_DIVY_W;
         end
         ST_DIVY_W: begin
            if (!status.div_busy) begin
               op       = OP_CY_END;
               state_in = ST_VEC;
            end
         end
         ST_VEC: begin
            op       = OP_VEC;
            state_in = ST_PHI;
         end
         ST_PHI: begin
            op       = OP_PHI_GO;
            state_in = ST_PHI_W;
         end
         ST_PHI_W: begin
            if (!status.div_busy) begin
               op       = OP_ROT_GO;
               state_in = ST_ROT_W;
            end
         end
         ST_ROT_W: begin
            if (!status.cordic_busy) begin
               op       = OP_ROT_END;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            op       = OP_MAC_GO;
            state_in = ST_MAC_W;
         end
         ST_MAC_W: begin
            if (!status.mac_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               op       = OP_EMIT;
               state_in = status.last ? ST_IDLE : ST_PHI;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/bulge_arc_tessellator_core.sv */
// Top level of the bulge arc tessellator: controller plus datapath.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  start_x, start_y, end_x, end_y, bulge
//   rsp      out        rsp_tvalid/rsp_tready  point_x, point_y, point_index; tlast
//
// One arc runs a setup (a 30-step CORDIC atan and two 60-step divisions
// for the centre) and then, per point, a 60-step division for the angle,
// a 30-step CORDIC rotation and a multiply-accumulate of the point.
// A new request is taken only when the previous arc is done; the last point
// may still wait in the result register. Reset is synchronous, active high.
// A stalled result holds the point sequencer until the beat is taken.
module bulge_arc_tessellator_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // start_x[23:0], start_y[47:24], end_x[71:48], end_y[95:72], bulge[111:96]
   input  logic [bat_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // point_x[23:0], point_y[47:24], point_index[51:48], zero[55:52]
   output logic [bat_pkg::RSP_W-1:0]  rsp_tdata,
   output logic                       rsp_tlast
);
   import bat_pkg::*;

   op_type     op;
   status_type status;

   bat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .op         (op)
   );

   bat_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/bat_checker.sv */
// Checker of the bulge arc tessellator: predicts the arc points of every request and compares.
module bat_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   input  logic                       req_tready,
   // start_x[23:0], start_y[47:24], end_x[71:48], end_y[95:72], bulge[111:96]
   input  logic [bat_pkg::REQ_W-1:0]  req_tdata,
   input  logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // point_x[23:0], point_y[47:24], point_index[51:48], zero[55:52]
   input  logic [bat_pkg::RSP_W-1:0]  rsp_tdata,
   input  logic                       rsp_tlast,
   output int                         errors,
   output int                         pending,
   output int                         points_seen
);
   import bat_pkg::*;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [INDEX_W-1:0] idx;
      logic               last;
   } arc_point_type;

   arc_point_type arc_point_q [$];

   // num / den rounded half away from zero
   function automatic longint round_div(input longint num, input longint den);
      longint unsigned un, ud, q;
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q  = (un + ud / 2) / ud;
      return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
   endfunction

   // a * c / 2^30 rounded half away from zero, product split to stay in 64 bits
   function automatic longint mul_q30(input longint a, input longint c);
      longint unsigned ua, uc, hi, lo, r;
      ua = (a < 0) ? -a : a;
      uc = (c < 0) ? -c : c;
      hi = (ua >> 32) * uc;
      lo = (ua & 64'hFFFF_FFFF) * uc;
      r  = (hi << 2) + ((lo + (64'd1 << 29)) >> 30);
      return ((a < 0) != (c < 0)) ? -longint'(r) : longint'(r);
   endfunction

   // quarter angle atan(mag / 4096) in 2^-32 turn, clamped
   function automatic longint quarter_angle(input longint mag);
      longint x, y, z, sx, sy;
      x = longint'(1) << 30;
      y = mag * 262144;
      z = 0;
      for (int k = 0; k < ITERS; k++) begin
         sx = y >>> k;
         sy = x >>> k;
         if (y >= 0) begin
            x += sx; y -= sy; z += longint'(ATAN_TAB[k]);
         end else begin
            x -= sx; y += sy; z -= longint'(ATAN_TAB[k]);
         end
      end
      if (z < 0) z = 0;
      if (z > (longint'(1) << 30) - 1) z = (longint'(1) << 30) - 1;
      return z;
   endfunction

   // cos and sin in Q2.30 of a 2^-32 turn angle
   function automatic void turn_cos_sin(input logic [31:0] u, output longint c,
                                        output longint s);
      longint x, y, z, sx, sy;
      x = longint'(GAIN_INV);
      y = 0;
      z = longint'(u[29:0]);
      for (int k = 0; k < ITERS; k++) begin
         sx = y >>> k;
         sy = x >>> k;
         if (z >= 0) begin
            x -= sx; y += sy; z -= longint'(ATAN_TAB[k]);
         end else begin
            x += sx; y -= sy; z += longint'(ATAN_TAB[k]);
         end
      end
      case (u[31:30])
         2'd0: begin c = x;  s = y;  end
         2'd1: begin c = -y; s = x;  end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
   endfunction

   // Q.24 to Q15.8, rounded and saturated
   function automatic logic [COORD_W-1:0] to_coord(input longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > 8388607) r = 8388607;
      if (r < -8388608) r = -8388608;
      return r[COORD_W-1:0];
   endfunction

   // queue the arc points one request produces
   function automatic void tessellate(input logic [REQ_W-1:0] d);
      longint x1, y1, x2, y2, b, dx, dy, mag, ang, t, cx, cy, vx, vy, f, c, s;
      int n;
      logic [31:0] u;
      arc_point_type p;
      x1 = $signed(d[23:0]);
      y1 = $signed(d[47:24]);
      x2 = $signed(d[71:48]);
      y2 = $signed(d[95:72]);
      b  = $signed(d[111:96]);
      dx = x2 - x1;
      dy = y2 - y1;
      if (b == 0 || (dx == 0 && dy == 0)) return;
      mag = (b < 0) ? -b : b;
      n = 4;
      for (int j = 0; j < NUM_THRESH; j++)
         if (mag >= longint'(SEG_THRESH[j])) n++;
      ang = 4 * quarter_angle(mag);
      t  = 16777216 - b * b;
      cx = (x1 + x2) * 32768 + round_div(-dy * 4 * t, b);
      cy = (y1 + y2) * 32768 + round_div(dx * 4 * t, b);
      vx = x1 * 65536 - cx;
      vy = y1 * 65536 - cy;
      for (int i = 1; i < n; i++) begin
         f = (ang * i) / n;
         u = f[31:0];
         if (b < 0) u = -u;
         turn_cos_sin(u, c, s);
         p.x    = to_coord(cx + mul_q30(vx, c) - mul_q30(vy, s));
         p.y    = to_coord(cy + mul_q30(vx, s) + mul_q30(vy, c));
         p.idx  = i[INDEX_W-1:0];
         p.last = (i == n - 1);
         arc_point_q.insert(arc_point_q.size(), p);
      end
   endfunction

   // predict on each request beat, compare each point beat with the oldest expectation
   always @(posedge clock) begin
      arc_point_type exp_pt;
      if (!reset) begin
         if (req_tvalid && req_tready) tessellate(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            points_seen++;
            if (arc_point_q.size() == 0) begin
               $error("unexpected point beat %h", rsp_tdata);
               errors++;
            end else begin
               exp_pt = arc_point_q.pop_front();
               if (rsp_tdata[23:0] !== exp_pt.x) begin
                  $error("point_x exp %h got %h", exp_pt.x, rsp_tdata[23:0]); errors++;
               end
               if (rsp_tdata[47:24] !== exp_pt.y) begin
                  $error("point_y exp %h got %h", exp_pt.y, rsp_tdata[47:24]); errors++;
               end
               if (rsp_tdata[51:48] !== exp_pt.idx) begin
                  $error("point_index exp %0d got %0d", exp_pt.idx, rsp_tdata[51:48]);
                  errors++;
               end
               if (rsp_tdata[55:52] !== 4'd0) begin
                  $error("pad exp 0 got %h", rsp_tdata[55:52]); errors++;
               end
               if (rsp_tlast !== exp_pt.last) begin
                  $error("last_point exp %b got %b", exp_pt.last, rsp_tlast); errors++;
               end
            end
         end
         pending = arc_point_q.size();
      end
   end

endmodule

/* tb/bulge_arc_tessellator_core_tb.sv */
// Testbench top of the bulge arc tessellator: stimulus, stalls, watchdog and verdict.
module bulge_arc_tessellator_core_tb;
   import bat_pkg::*;

   localparam int WATCH_LIMIT = 8000;
   localparam int NUM_RANDOM  = 300;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tlast;
   int                errors, pending, points_seen;
   int                arcs_sent  = 0;
   int                idle_cycles = 0;
   bit                burst      = 1'b0;

   always #5 clock = ~clock;

   bulge_arc_tessellator_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   bat_checker i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .errors(errors), .pending(pending), .points_seen(points_seen)
   );

   // end the run when no beat moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("[bulge_arc_tessellator_core] ERROR");
         $finish;
      end
   end

   // stall the point channel for a random gap before each beat, none in burst phases
   initial begin
      int k;
      @(negedge reset);
      forever begin
         k = burst ? 0 : $urandom_range(0, 7);
         if (k > 0) begin
            rsp_tready <= 1'b0;
            repeat (k) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // hand one arc request over after a random gap, none in burst phases
   task automatic send_arc(input logic [23:0] sx, input logic [23:0] sy,
                           input logic [23:0] ex, input logic [23:0] ey,
                           input logic [15:0] b);
      int g;
      g = burst ? 0 : $urandom_range(0, 7);
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, ey, ex, sy, sx};
      do @(posedge clock); while (!req_tready);
      arcs_sent++;
   endtask

   // random coordinate: full range, moderate, or tight
   function automatic logic [23:0] rand_coord(input int mode);
      case (mode)
         0: return 24'($urandom());
         1: return 24'($signed($urandom_range(0, 131071)) - 65536);
         default: return 24'($signed($urandom_range(0, 2047)) - 1024);
      endcase
   endfunction

   initial begin
      logic [23:0] sx, sy, ex, ey;
      logic [15:0] b;
      int valid_cnt, mode, pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty arcs, bulge extremes, every point-count threshold, coordinate extremes
      send_arc(24'h000100, 24'h000200, 24'h000500, 24'h000300, 16'h0000);
      send_arc(24'h001000, 24'hFFF000, 24'h001000, 24'hFFF000, 16'h1000);
      send_arc(24'h000000, 24'h000000, 24'h000A00, 24'h000000, 16'h8000);
      send_arc(24'h000000, 24'h000000, 24'h000A00, 24'h000000, 16'h7FFF);
      foreach (SEG_THRESH[j]) begin
         send_arc(24'hFFFC00, 24'h000400, 24'h000800, 24'hFFF000,
                  SEG_THRESH[j] - 16'd1);
         send_arc(24'h000400, 24'hFFFC00, 24'hFFF000, 24'h000800,
                  -SEG_THRESH[j]);
      end
      send_arc(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 16'h1000);
      send_arc(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, 16'hF000);
      send_arc(24'h000000, 24'h000000, 24'h000001, 24'h000000, 16'h0001);
      send_arc(24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF, 16'hFFFF);
      send_arc(24'h400000, 24'h400000, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF);

      // random: mostly real arcs, some empty ones, phases with and without idling
      valid_cnt = 0;
      while (valid_cnt < NUM_RANDOM) begin
         if (valid_cnt % 40 == 0) burst = ($urandom_range(0, 3) == 0);
         mode = $urandom_range(0, 9);
         mode = (mode < 3) ? 0 : (mode < 9) ? 1 : 2;
         sx = rand_coord(mode); sy = rand_coord(mode);
         ex = rand_coord(mode); ey = rand_coord(mode);
         b  = 16'($urandom());
         if ($urandom_range(0, 3) == 0) b = 16'($signed($urandom_range(0, 8191)) - 4096);
         pick = $urandom_range(0, 19);
         if (pick == 0) b = 16'h0000;
         else if (pick == 1) begin ex = sx; ey = sy; end
         else if (b == 16'h0000 || (ex == sx && ey == sy)) b = 16'h0800;
         send_arc(sx, sy, ex, ey, b);
         if (pick > 1) valid_cnt++;
      end
      req_tvalid <= 1'b0;
      burst = 1'b0;

      // drain the points still due, then let a trailing empty arc settle
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);

      $display("Sent %0d arc requests; %0d arc points checked.", arcs_sent, points_seen);
      if (errors == 0 && pending == 0) begin
         $display("[bulge_arc_tessellator_core] OK");
      end else begin
         $display("[bulge_arc_tessellator_core] ERROR");
      end
      $finish;
   end

endmodule

/* bulge_arc_tessellator_core.f */
rtl/core/bat_pkg.sv
rtl/core/bat_cordic.sv
rtl/core/bat_div.sv
rtl/core/bat_datapath.sv
rtl/core/bat_ctrl.sv
rtl/core/bulge_arc_tessellator_core.sv
tb/bat_checker.sv
tb/bulge_arc_tessellator_core_tb.sv
